/* rtl/ipru_pkg.sv */
package ipru_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int MAX_SCALE = 16;

  // field widths fixed by the interface
  localparam int SCALE_BITS    = 5;
  localparam int WIDTH_BITS    = 11;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 11;
  localparam int COLOR_BITS    = 8;
  localparam int PIXEL_BITS    = 3 * COLOR_BITS;

  // derived internal widths
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;  // column / address
  localparam int WW = $clog2(MAX_WIDTH + 1);                     // effective width
  localparam int SW = $clog2(MAX_SCALE + 1);                     // effective scale
  localparam int RW = $clog2(MAX_SCALE);                         // repeat / line count

  localparam logic [CFG_IDX_BITS-1:0] REG_SCALE = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH = 1'b1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_PAD   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PIX,
    ST_PAD,
    ST_TICK
  } ipru_state_e;

  typedef struct packed {
    logic in_ready;
    logic take_pixel;
    logic take_tick;
    logic emit_pixel;
    logic emit_pad;
    logic emit_replay;
  } ipru_cmd_t;

  typedef struct packed {
    logic replaying;
    logic rep_last;
    logic pad_last;
    logic needs_pad;
    logic out_free;
  } ipru_status_t;

endpackage

/* rtl/ipru_if.sv */
interface ipru_in_if;
  import ipru_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [COLOR_BITS-1:0] blue_in;
  logic [COLOR_BITS-1:0] green_in;
  logic [COLOR_BITS-1:0] red_in;

  modport source (output valid, operation, blue_in, green_in, red_in, input ready);
  modport sink   (input valid, operation, blue_in, green_in, red_in, output ready);
endinterface

interface ipru_out_if;
  import ipru_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  unit_kind;
  logic [COLOR_BITS-1:0] blue_out;
  logic [COLOR_BITS-1:0] green_out;
  logic [COLOR_BITS-1:0] red_out;
  logic                  row_end;
  logic                  run_last;

  modport source (output valid, unit_kind, blue_out, green_out, red_out, row_end, run_last,
                  input ready);
  modport sink   (input valid, unit_kind, blue_out, green_out, red_out, row_end, run_last,
                  output ready);
endinterface

/* rtl/integer_pixel_replication_upscaler.sv */
// Nearest-neighbor integer upscaler for 24-bit scanlines.
// in_if carries requests: operation 0 brings one source pixel, operation 1 is a
// replay tick. out_if delivers output units: a pixel, or one zero pad byte, with
// row_end on the last unit of an output row and run_last on the last unit of a
// request. cfg_we_i/cfg_index_i/cfg_data_i write scale_factor (index 0) and
// source_width (index 1); write them only while the block is idle.
// A pixel request is accepted, then emits S units of the pixel and, after the last
// pixel of a row, P pad units (S = scale, P = pad bytes), one unit per cycle
// through the output register while the receiver keeps it free. A tick is accepted
// with the line memory read issued, then loads the output register. Ignored requests
// (pixel while replaying, tick while not replaying) are dropped and give no unit.
// The row is kept in a 1024 x 24 line memory; after a row the next S-1 output
// rows come from ticks. Reset clears counters and the output valid flag and sets
// scale and width to 1; the line memory is not cleared.
// When the receiver stalls, the unit waits in the output register and emission
// pauses; a new request is accepted once the previous one is fully emitted.
module integer_pixel_replication_upscaler
  import ipru_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  ipru_in_if.sink                  in_if,
  ipru_out_if.source               out_if
);

  ipru_cmd_t    cmd;
  ipru_status_t status;

  ipru_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_if.valid),
    .in_op_i   (in_if.operation),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  ipru_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .blue_i     (in_if.blue_in),
    .green_i    (in_if.green_in),
    .red_i      (in_if.red_in),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .unit_kind_o(out_if.unit_kind),
    .blue_o     (out_if.blue_out),
    .green_o    (out_if.green_out),
    .red_o      (out_if.red_out),
    .row_end_o  (out_if.row_end),
    .run_last_o (out_if.run_last)
  );

  assign in_if.ready = cmd.in_ready;

endmodule

/* rtl/ipru_ram.sv */
module ipru_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ipru_ctrl.sv */
module ipru_ctrl
  import ipru_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_op_i,
  input  ipru_status_t status_i,
  output ipru_cmd_t    cmd_o
);

  ipru_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_op_i == OP_PIXEL && !status_i.replaying) begin
            state_d = ST_PIX;
          end else if (in_op_i == OP_TICK && status_i.replaying) begin
            state_d = ST_TICK;
          end
        end
      end
      ST_PIX: begin
        if (status_i.out_free && status_i.rep_last) begin
          state_d = status_i.needs_pad ? ST_PAD : ST_IDLE;
        end
      end
      ST_PAD: begin
        if (status_i.out_free && status_i.pad_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_TICK: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready   = 1'b1;
        cmd_o.take_pixel = in_valid_i && in_op_i == OP_PIXEL && !status_i.replaying;
        cmd_o.take_tick  = in_valid_i && in_op_i == OP_TICK && status_i.replaying;
      end
      ST_PIX:  cmd_o.emit_pixel  = status_i.out_free;
      ST_PAD:  cmd_o.emit_pad    = status_i.out_free;
      ST_TICK: cmd_o.emit_replay = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

/* rtl/ipru_datapath.sv */
module ipru_datapath
  import ipru_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic [COLOR_BITS-1:0]    blue_i,
  input  logic [COLOR_BITS-1:0]    green_i,
  input  logic [COLOR_BITS-1:0]    red_i,
  input  ipru_cmd_t                cmd_i,
  output ipru_status_t             status_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     unit_kind_o,
  output logic [COLOR_BITS-1:0]    blue_o,
  output logic [COLOR_BITS-1:0]    green_o,
  output logic [COLOR_BITS-1:0]    red_o,
  output logic                     row_end_o,
  output logic                     run_last_o
);

  // configuration, held as effective values
  logic [SW-1:0] scale_q;
  logic [WW-1:0] width_q;
  logic [SCALE_BITS-1:0] scale_raw;
  logic [WIDTH_BITS-1:0] width_raw;
  logic [SW-1:0] scale_eff;
  logic [WW-1:0] width_eff;
  logic [1:0]    pad;
  logic [1:0]    row_bytes_mod;

  // row capture and replay state
  logic [CW-1:0] col_q, col_d, col_eff;
  logic [WW-1:0] col_inc;
  logic          row_last;
  logic          replaying_q, replaying_d;
  logic [RW-1:0] line_q, line_d;
  logic [WW-1:0] rcol_q, rcol_d;
  logic [RW-1:0] rrep_q, rrep_d;
  logic [1:0]    rpad_q, rpad_d;

  // current item
  logic [PIXEL_BITS-1:0] pix_q;
  logic                  last_q;
  logic [RW-1:0]         rep_q, rep_d;
  logic [1:0]            epad_q, epad_d;
  logic                  tkind_q, tkind_d;
  logic                  tend_q, tend_d;

  // tick evaluation
  logic          tick_pixel;
  logic [SW-1:0] rrep_inc;
  logic [2:0]    rpad_inc;
  logic          tick_done;
  logic          rep_last, pad_last;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic                  okind_q;
  logic [PIXEL_BITS-1:0] opix_q;
  logic                  oend_q, olast_q;
  logic [PIXEL_BITS-1:0] ram_rdata;

  assign scale_raw = cfg_data_i[SCALE_BITS-1:0];
  assign width_raw = cfg_data_i[WIDTH_BITS-1:0];

  always_comb begin
    if (scale_raw == '0) begin
      scale_eff = SW'(1);
    end else if (int'(scale_raw) > MAX_SCALE) begin
      scale_eff = SW'(MAX_SCALE);
    end else begin
      scale_eff = SW'(scale_raw);
    end
    if (width_raw == '0) begin
      width_eff = WW'(1);
    end else if (int'(width_raw) > MAX_WIDTH) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(width_raw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SW'(1);
      width_q <= WW'(1);
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_SCALE) begin
        scale_q <= scale_eff;
      end else if (cfg_index_i == REG_WIDTH) begin
        width_q <= width_eff;
      end
    end
  end

  // only the low two bits of width and scale decide the row length mod four
  assign row_bytes_mod = 2'(4'(width_q[1:0]) * 4'(scale_q[1:0]) * 4'd3);
  assign pad           = 2'(3'd4 - {1'b0, row_bytes_mod});

  // pixel capture
  assign col_eff  = (int'(col_q) >= MAX_WIDTH) ? '0 : col_q;
  assign col_inc  = WW'(col_eff) + WW'(1);
  assign row_last = col_inc >= width_q;

  assign rep_last = (SW'(rep_q) + SW'(1)) == scale_q;
  assign pad_last = (3'(epad_q) + 3'd1) == {1'b0, pad};

  // replay step for one tick
  assign tick_pixel = rcol_q < width_q;
  assign rrep_inc   = SW'(rrep_q) + SW'(1);
  assign rpad_inc   = 3'(rpad_q) + 3'd1;

  always_comb begin
    col_d       = col_q;
    replaying_d = replaying_q;
    line_d      = line_q;
    rcol_d      = rcol_q;
    rrep_d      = rrep_q;
    rpad_d      = rpad_q;
    rep_d       = rep_q;
    epad_d      = epad_q;
    tkind_d     = tkind_q;
    tend_d      = tend_q;
    tick_done   = 1'b0;

    if (cmd_i.take_pixel) begin
      rep_d  = '0;
      epad_d = '0;
      if (row_last) begin
        col_d = '0;
        if (scale_q > SW'(1)) begin
          replaying_d = 1'b1;
          line_d      = '0;
          rcol_d      = '0;
          rrep_d      = '0;
          rpad_d      = '0;
        end
      end else begin
        col_d = col_inc[CW-1:0];
      end
    end

    if (cmd_i.emit_pixel) begin
      rep_d = rep_last ? '0 : rep_q + RW'(1);
    end
    if (cmd_i.emit_pad) begin
      epad_d = epad_q + 2'd1;
    end

    if (cmd_i.take_tick) begin
      if (tick_pixel) begin
        tkind_d = KIND_PIXEL;
        if (rrep_inc >= scale_q) begin
          rrep_d = '0;
          rcol_d = rcol_q + WW'(1);
        end else begin
          rrep_d = rrep_inc[RW-1:0];
        end
        tick_done = (rcol_d >= width_q) && (pad == 2'd0);
      end else begin
        tkind_d   = KIND_PAD;
        rpad_d    = rpad_inc[1:0];
        tick_done = rpad_inc >= {1'b0, pad};
      end
      tend_d = tick_done;
      if (tick_done) begin
        rcol_d = '0;
        rrep_d = '0;
        rpad_d = '0;
        // end of line: stop once scale minus one copies are out
        if ((SW + 1)'(line_q) + (SW + 1)'(2) >= (SW + 1)'(scale_q)) begin
          replaying_d = 1'b0;
          line_d      = '0;
        end else begin
          line_d = line_q + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      replaying_q <= 1'b0;
      line_q      <= '0;
      rcol_q      <= '0;
      rrep_q      <= '0;
      rpad_q      <= '0;
      rep_q       <= '0;
      epad_q      <= '0;
      tkind_q     <= KIND_PIXEL;
      tend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      replaying_q <= replaying_d;
      line_q      <= line_d;
      rcol_q      <= rcol_d;
      rrep_q      <= rrep_d;
      rpad_q      <= rpad_d;
      rep_q       <= rep_d;
      epad_q      <= epad_d;
      tkind_q     <= tkind_d;
      tend_q      <= tend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_pixel) begin
      pix_q  <= {red_i, green_i, blue_i};
      last_q <= row_last;
    end
  end

  ipru_ram #(
    .WIDTH(PIXEL_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_row_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.take_pixel),
    .waddr_i(col_eff),
    .wdata_i({red_i, green_i, blue_i}),
    .re_i   (cmd_i.take_tick && tick_pixel),
    .raddr_i(rcol_q[CW-1:0]),
    .rdata_o(ram_rdata)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.emit_pixel || cmd_i.emit_pad || cmd_i.emit_replay) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_pixel) begin
      okind_q <= KIND_PIXEL;
      opix_q  <= pix_q;
      oend_q  <= last_q && (pad == 2'd0) && rep_last;
      olast_q <= rep_last && !(last_q && (pad != 2'd0));
    end else if (cmd_i.emit_pad) begin
      okind_q <= KIND_PAD;
      opix_q  <= '0;
      oend_q  <= pad_last;
      olast_q <= pad_last;
    end else if (cmd_i.emit_replay) begin
      okind_q <= tkind_q;
      opix_q  <= (tkind_q == KIND_PAD) ? '0 : ram_rdata;
      oend_q  <= tend_q;
      olast_q <= 1'b1;
    end
  end

  assign status_o.replaying = replaying_q;
  assign status_o.rep_last  = rep_last;
  assign status_o.pad_last  = pad_last;
  assign status_o.needs_pad = last_q && (pad != 2'd0);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign unit_kind_o = okind_q;
  assign blue_o      = opix_q[COLOR_BITS-1:0];
  assign green_o     = opix_q[2*COLOR_BITS-1:COLOR_BITS];
  assign red_o       = opix_q[3*COLOR_BITS-1:2*COLOR_BITS];
  assign row_end_o   = oend_q;
  assign run_last_o  = olast_q;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench
  import ipru_pkg::*;
;

  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEM_TARGET = 430;

  typedef struct packed {
    logic                  operation;
    logic [COLOR_BITS-1:0] blue;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] red;
  } request_t;

  typedef struct packed {
    logic                  unit_kind;
    logic [COLOR_BITS-1:0] blue;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] red;
    logic                  row_end;
    logic                  run_last;
  } unit_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  ipru_in_if  req_bus ();
  ipru_out_if unit_bus ();

  integer_pixel_replication_upscaler u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_if       (req_bus),
    .out_if      (unit_bus)
  );

  request_t request_q [$];
  unit_t    expected_units [$];

  int  cycle_cnt = 0;
  int  err_cnt = 0;
  int  item_cnt = 0;
  int  units_seen = 0;
  int  stall_left = 0;
  bit  stall_done = 1'b0;
  logic steady;

  // scaler state as the block should hold it
  logic [PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
  int          col_next = 0;
  bit          replay_on = 1'b0;
  int          rp_line = 0;
  int          rp_col = 0;
  int          rp_rep = 0;
  int          rp_pad = 0;
  int          mem_fill = 0;
  logic [4:0]  scale_reg = 5'd1;
  logic [10:0] width_reg = 11'd1;

  // no random idling in one window out of four
  assign steady = ((cycle_cnt / 1500) % 4) == 1;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int eff_scale(logic [4:0] v);
    if (v == 0) return 1;
    if (v > MAX_SCALE) return MAX_SCALE;
    return int'(v);
  endfunction

  function automatic int eff_width(logic [10:0] v);
    if (v == 0) return 1;
    if (v > MAX_WIDTH) return MAX_WIDTH;
    return int'(v);
  endfunction

  function automatic int pad_bytes(int s, int w);
    return (4 - ((w * s * 3) % 4)) % 4;
  endfunction

  function automatic unit_t make_unit(logic kind, logic [PIXEL_BITS-1:0] px, logic rend);
    unit_t u;
    u.unit_kind = kind;
    u.blue      = px[7:0];
    u.green     = px[15:8];
    u.red       = px[23:16];
    u.row_end   = rend;
    u.run_last  = 1'b0;
    return u;
  endfunction

  task automatic close_replay_line(input int s);
    rp_line++;
    rp_col = 0;
    rp_rep = 0;
    rp_pad = 0;
    if (rp_line + 1 >= s) begin
      replay_on = 1'b0;
      rp_line = 0;
    end
  endtask

  // works out the output units caused by one accepted request
  task automatic expand_request(input request_t rq);
    unit_t                 batch [$];
    int                    s;
    int                    w;
    int                    pad;
    logic [PIXEL_BITS-1:0] px;
    bit                    last;
    bit                    done;
    s   = eff_scale(scale_reg);
    w   = eff_width(width_reg);
    pad = pad_bytes(s, w);
    if (rq.operation == OP_PIXEL) begin
      if (!replay_on) begin
        px = {rq.red, rq.green, rq.blue};
        if (col_next >= MAX_WIDTH) col_next = 0;
        line_mem[col_next] = px;
        if (col_next + 1 > mem_fill) mem_fill = col_next + 1;
        last = (col_next + 1 >= w);
        for (int i = 0; i < s; i++) begin
          batch.push_back(make_unit(KIND_PIXEL, px, last && pad == 0 && i + 1 == s));
        end
        if (last) begin
          for (int i = 0; i < pad; i++) begin
            batch.push_back(make_unit(KIND_PAD, '0, i + 1 == pad));
          end
          col_next = 0;
          if (s > 1) begin
            replay_on = 1'b1;
            rp_line = 0;
            rp_col = 0;
            rp_rep = 0;
            rp_pad = 0;
          end
        end else begin
          col_next++;
        end
      end
    end else if (replay_on) begin
      if (rp_col < w) begin
        px = (rp_col < MAX_WIDTH) ? line_mem[rp_col] : '0;
        rp_rep++;
        if (rp_rep >= s) begin
          rp_rep = 0;
          rp_col++;
        end
        done = (rp_col >= w) && (pad == 0);
        batch.push_back(make_unit(KIND_PIXEL, px, done));
      end else begin
        rp_pad++;
        done = (rp_pad >= pad);
        batch.push_back(make_unit(KIND_PAD, '0, done));
      end
      if (done) close_replay_line(s);
    end
    if (batch.size() > 0) batch[batch.size() - 1].run_last = 1'b1;
    foreach (batch[i]) expected_units.push_back(batch[i]);
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
    end else if (!(req_bus.valid && !req_bus.ready)) begin
      if (req_bus.valid) expand_request(request_q.pop_front());
      if (request_q.size() != 0 && (steady || $urandom_range(0, 99) >= 32)) begin
        req_bus.valid     <= 1'b1;
        req_bus.operation <= request_q[0].operation;
        req_bus.blue_in   <= request_q[0].blue;
        req_bus.green_in  <= request_q[0].green;
        req_bus.red_in    <= request_q[0].red;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // one long hold-off while requests are still queued so the block backs up into its input
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!stall_done && units_seen >= 100 && request_q.size() > 20) begin
      stall_left <= 400;
      stall_done <= 1'b1;
    end
  end

  // unit monitor and receiver back-pressure
  always @(posedge clk_i) begin
    unit_t got;
    unit_t want;
    if (!rst_ni) begin
      unit_bus.ready <= 1'b0;
    end else begin
      if (unit_bus.valid && unit_bus.ready) begin
        got = {unit_bus.unit_kind, unit_bus.blue_out, unit_bus.green_out, unit_bus.red_out,
               unit_bus.row_end, unit_bus.run_last};
        units_seen++;
        if (expected_units.size() == 0) begin
          $error("unexpected output unit %h", got);
          err_cnt++;
        end else begin
          want = expected_units.pop_front();
          if (got.unit_kind != want.unit_kind) begin
            $error("unit_kind: expected %0d, got %0d", want.unit_kind, got.unit_kind);
            err_cnt++;
          end
          if (got.blue != want.blue) begin
            $error("blue_out: expected %0h, got %0h", want.blue, got.blue);
            err_cnt++;
          end
          if (got.green != want.green) begin
            $error("green_out: expected %0h, got %0h", want.green, got.green);
            err_cnt++;
          end
          if (got.red != want.red) begin
            $error("red_out: expected %0h, got %0h", want.red, got.red);
            err_cnt++;
          end
          if (got.row_end != want.row_end) begin
            $error("row_end: expected %0d, got %0d", want.row_end, got.row_end);
            err_cnt++;
          end
          if (got.run_last != want.run_last) begin
            $error("run_last: expected %0d, got %0d", want.run_last, got.run_last);
            err_cnt++;
          end
        end
      end
      unit_bus.ready <= (stall_left == 0) && (steady || $urandom_range(0, 99) >= 32);
    end
  end

  task automatic add_request(input logic op, input logic [PIXEL_BITS-1:0] px);
    request_t rq;
    rq.operation = op;
    {rq.red, rq.green, rq.blue} = px;
    request_q.push_back(rq);
    item_cnt++;
  endtask

  task automatic add_ticks(input int n);
    for (int i = 0; i < n; i++) add_request(OP_TICK, PIXEL_BITS'($urandom()));
  endtask

  task automatic wait_quiet();
    do @(posedge clk_i);
    while (request_q.size() != 0 || req_bus.valid || expected_units.size() != 0);
    // ignored requests give no unit, let the block finish them
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_BITS-1:0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_SCALE) scale_reg = val[4:0];
    else width_reg = val[10:0];
  endtask

  task automatic set_random_config();
    int pick;
    int sc;
    int wd;
    pick = $urandom_range(0, 99);
    if (pick < 20) sc = 1;
    else if (pick < 60) sc = $urandom_range(2, 3);
    else if (pick < 80) sc = $urandom_range(4, 6);
    else if (pick < 88) sc = 0;
    else if (pick < 95) sc = $urandom_range(7, 15);
    else sc = $urandom_range(16, 31);
    if (eff_scale(5'(sc)) >= 7) wd = $urandom_range(0, 2);
    else if (eff_scale(5'(sc)) <= 2 && $urandom_range(0, 9) == 0) wd = $urandom_range(7, 40);
    else wd = $urandom_range(0, 6);
    // a replay in progress must not reach columns that were never stored
    if (replay_on && eff_width(11'(wd)) > mem_fill) wd = mem_fill;
    if ($urandom_range(0, 1) == 0) begin
      write_reg(REG_SCALE, sc);
      write_reg(REG_WIDTH, wd);
    end else begin
      write_reg(REG_WIDTH, wd);
      write_reg(REG_SCALE, sc);
    end
  endtask

  // mostly complete rows with their full replay, some cut short or padded with noise
  task automatic queue_rows(input int n_rows);
    int s;
    int w;
    int npix;
    int ticks;
    s = eff_scale(scale_reg);
    w = eff_width(width_reg);
    for (int r = 0; r < n_rows && item_cnt < ITEM_TARGET; r++) begin
      npix  = w;
      ticks = (s - 1) * (w * s + pad_bytes(s, w));
      case ($urandom_range(0, 19))
        0: npix = $urandom_range(0, w - 1);
        1: ticks = $urandom_range(0, ticks);
        2: ticks += $urandom_range(1, 3);
        default: ;
      endcase
      for (int i = 0; i < npix && item_cnt < ITEM_TARGET; i++) begin
        add_request(OP_PIXEL, PIXEL_BITS'($urandom()));
      end
      for (int i = 0; i < ticks && item_cnt < ITEM_TARGET; i++) begin
        if ($urandom_range(0, 29) == 0) add_request(OP_PIXEL, PIXEL_BITS'($urandom()));
        add_request(OP_TICK, PIXEL_BITS'($urandom()));
      end
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    req_bus.valid     = 1'b0;
    req_bus.operation = OP_PIXEL;
    req_bus.blue_in   = '0;
    req_bus.green_in  = '0;
    req_bus.red_in    = '0;
    unit_bus.ready    = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero registers count as one; tick with no replay running is ignored
    write_reg(REG_SCALE, 0);
    write_reg(REG_WIDTH, 0);
    add_request(OP_PIXEL, 24'hFFFFFF);
    add_request(OP_TICK, 24'h000000);
    wait_quiet();

    // 2x single pixel: two pad bytes per row, one replayed line, pixel ignored in replay
    write_reg(REG_SCALE, 2);
    write_reg(REG_WIDTH, 1);
    add_request(OP_PIXEL, 24'h000000);
    add_request(OP_TICK, 24'hFFFFFF);
    add_request(OP_PIXEL, 24'h123456);
    add_ticks(3);
    wait_quiet();

    // clamped scale and width, then width cut mid-row and scale cut mid-replay
    write_reg(REG_SCALE, 31);
    write_reg(REG_WIDTH, 2047);
    add_request(OP_PIXEL, 24'h00FF00);
    add_request(OP_PIXEL, 24'hFF00FF);
    wait_quiet();
    write_reg(REG_WIDTH, 2);
    add_request(OP_PIXEL, 24'hA5C35A);
    add_ticks(3);
    wait_quiet();
    write_reg(REG_SCALE, 2);
    add_ticks(3);
    wait_quiet();

    // padding vanishes mid-replay while in the pad bytes
    write_reg(REG_SCALE, 3);
    write_reg(REG_WIDTH, 1);
    add_request(OP_PIXEL, 24'h3C96E1);
    add_ticks(4);
    wait_quiet();
    write_reg(REG_SCALE, 4);
    add_ticks(10);
    wait_quiet();

    while (item_cnt < ITEM_TARGET) begin
      set_random_config();
      queue_rows($urandom_range(1, 3));
      wait_quiet();
    end

    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && expected_units.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/ipru_pkg.sv
rtl/ipru_if.sv
rtl/ipru_ram.sv
rtl/ipru_ctrl.sv
rtl/ipru_datapath.sv
rtl/integer_pixel_replication_upscaler.sv
sim/testbench.sv
